>>> rtl/i2cm_pkg.sv
// shared types and constants of the i2c master bit engine
`timescale 1ns / 1ps

package i2cm_pkg;

    // command codes carried in the func field
    localparam logic [2:0] FUNC_NONE      = 3'd0;
    localparam logic [2:0] FUNC_START     = 3'd1;
    localparam logic [2:0] FUNC_STOP      = 3'd2;
    localparam logic [2:0] FUNC_SEND      = 3'd3;
    localparam logic [2:0] FUNC_WAIT_ACK  = 3'd4;
    localparam logic [2:0] FUNC_READ      = 3'd5;
    localparam logic [2:0] FUNC_REG_WRITE = 3'd6;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    localparam int HALF_W = 10;
    localparam int TOUT_W = 16;
    localparam logic [HALF_W-1:0] HALF_RESET = 10'd120;
    localparam logic [TOUT_W-1:0] TOUT_RESET = 16'd250;

    // bits per byte on the bus
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // register write progress: none, address, register, data byte
    localparam logic [1:0] WSTEP_NONE = 2'd0;
    localparam logic [1:0] WSTEP_ADDR = 2'd1;
    localparam logic [1:0] WSTEP_REG  = 2'd2;
    localparam logic [1:0] WSTEP_DATA = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START1,
        PH_START2,
        PH_STOP1,
        PH_STOP2,
        PH_STOP3,
        PH_ACK1,
        PH_ACK2,
        PH_ACKPOLL,
        PH_TX1,
        PH_TX2,
        PH_RX1,
        PH_RX2,
        PH_RXA1,
        PH_RXA2
    } phase_t;

    // one result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } res_t;

endpackage

>>> rtl/i2cm_cmd_if.sv
// request channel interface of the i2c master bit engine
`timescale 1ns / 1ps

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic [7:0] register_byte;
    logic [7:0] payload_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (
        output valid, func, tx_byte, register_byte, payload_byte, send_ack, sda_in,
        input  ready
    );
    modport sink (
        input  valid, func, tx_byte, register_byte, payload_byte, send_ack, sda_in,
        output ready
    );
endinterface

>>> rtl/i2cm_res_if.sv
// result channel interface of the i2c master bit engine
`timescale 1ns / 1ps

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;

    modport source (
        output valid, scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte,
               ack_missing,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte,
               ack_missing,
        output ready
    );
endinterface

>>> rtl/i2c_master_bit_engine.sv
// i2c master bit engine: one tick request in, one line and status result out
// a request's result is registered into the output register, or into the skid entry if the output register is full
// throughput: one request per cycle while the skid entry is empty; the tick update is one pass of next-state logic
// output side: output register plus one skid entry, so input stalls only when both are full
// reset: bus lines high and driven, engine idle, half period 120 and ack timeout 250 ticks
`timescale 1ns / 1ps

module i2c_master_bit_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data,
    i2cm_cmd_if.sink                        cmd,
    i2cm_res_if.source                      res
);
    import i2cm_pkg::*;

    // configuration
    logic [HALF_W-1:0] half_reg;
    logic [TOUT_W-1:0] tout_reg;

    // engine state
    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [HALF_W-1:0] delay_reg, delay_next;
    logic [TOUT_W-1:0] wait_reg, wait_next;
    logic [1:0]  wstep_reg, wstep_next;
    logic [7:0]  sreg_reg, sreg_next;
    logic [7:0]  spay_reg, spay_next;
    logic [7:0]  rcv_reg, rcv_next;
    logic        fail_reg, fail_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drive_reg, drive_next;
    logic        achoice_reg, achoice_next;
    logic        done_now;

    // output buffering
    res_t        out_reg, skid_reg, result;
    logic        out_valid_reg, skid_valid_reg;
    logic        push, pop;

    // scratch of the next-state pass
    logic              enter_en;
    phase_t            enter_ph;
    logic              fin;
    logic              do_poll;
    logic [TOUT_W-1:0] poll_cnt;
    logic [HALF_W-1:0] delay_dec;
    logic [HALF_W-1:0] hold;
    logic [3:0]        bit_inc;

    assign cmd.ready = !skid_valid_reg;
    assign push      = cmd.valid && cmd.ready;
    assign pop       = out_valid_reg && res.ready;
    assign hold      = (half_reg == '0) ? {{(HALF_W-1){1'b0}}, 1'b1} : half_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
            tout_reg <= TOUT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HALF_PERIOD)
            begin
                half_reg <= cfg_data[HALF_W-1:0];
            end
            else if (cfg_index == CFG_ACK_TIMEOUT)
            begin
                tout_reg <= cfg_data[TOUT_W-1:0];
            end
        end
    end

    // next state of the engine for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        delay_next   = delay_reg;
        wait_next    = wait_reg;
        wstep_next   = wstep_reg;
        sreg_next    = sreg_reg;
        spay_next    = spay_reg;
        rcv_next     = rcv_reg;
        fail_next    = fail_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        drive_next   = drive_reg;
        achoice_next = achoice_reg;
        enter_en     = 1'b0;
        enter_ph     = PH_IDLE;
        fin          = 1'b0;
        do_poll      = 1'b0;
        poll_cnt     = wait_reg;
        delay_dec    = (delay_reg != '0) ? delay_reg - 1'b1 : '0;
        bit_inc      = bit_reg + 4'd1;

        if (phase_reg == PH_IDLE)
        begin
            // command decode
            case (cmd.func)
                FUNC_START:
                begin
                    wstep_next = WSTEP_NONE;
                    enter_en   = 1'b1;
                    enter_ph   = PH_START1;
                end
                FUNC_STOP:
                begin
                    wstep_next = WSTEP_NONE;
                    enter_en   = 1'b1;
                    enter_ph   = PH_STOP1;
                end
                FUNC_SEND:
                begin
                    wstep_next = WSTEP_NONE;
                    shift_next = cmd.tx_byte;
                    bit_next   = '0;
                    enter_en   = 1'b1;
                    enter_ph   = PH_TX1;
                end
                FUNC_WAIT_ACK:
                begin
                    wstep_next = WSTEP_NONE;
                    enter_en   = 1'b1;
                    enter_ph   = PH_ACK1;
                end
                FUNC_READ:
                begin
                    wstep_next   = WSTEP_NONE;
                    achoice_next = cmd.send_ack;
                    shift_next   = '0;
                    bit_next     = '0;
                    enter_en     = 1'b1;
                    enter_ph     = PH_RX1;
                end
                FUNC_REG_WRITE:
                begin
                    shift_next = cmd.tx_byte;
                    sreg_next  = cmd.register_byte;
                    spay_next  = cmd.payload_byte;
                    wstep_next = WSTEP_ADDR;
                    enter_en   = 1'b1;
                    enter_ph   = PH_START1;
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg == PH_ACKPOLL)
        begin
            do_poll = 1'b1;
        end
        else
        begin
            // half period timer and phase sequencing
            delay_next = delay_dec;
            if (delay_dec == '0)
            begin
                case (phase_reg)
                    PH_START1:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_START2;
                    end
                    PH_START2:
                    begin
                        scl_next = 1'b0;
                        if (wstep_reg != WSTEP_NONE)
                        begin
                            bit_next = '0;
                            enter_en = 1'b1;
                            enter_ph = PH_TX1;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    PH_STOP1:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_STOP2;
                    end
                    PH_STOP2:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_STOP3;
                    end
                    PH_ACK1:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_ACK2;
                    end
                    PH_ACK2:
                    begin
                        phase_next = PH_ACKPOLL;
                        delay_next = '0;
                        wait_next  = '0;
                        poll_cnt   = '0;
                        do_poll    = 1'b1;
                    end
                    PH_TX1:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_TX2;
                    end
                    PH_TX2:
                    begin
                        scl_next = 1'b0;
                        bit_next = bit_inc;
                        if (bit_inc < BYTE_BITS)
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_TX1;
                        end
                        else if (wstep_reg != WSTEP_NONE)
                        begin
                            enter_en = 1'b1;
                            enter_ph = PH_ACK1;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    PH_RX1:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_RX2;
                    end
                    PH_RX2:
                    begin
                        bit_next = bit_inc;
                        enter_en = 1'b1;
                        enter_ph = (bit_inc < BYTE_BITS) ? PH_RX1 : PH_RXA1;
                    end
                    PH_RXA1:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_RXA2;
                    end
                    PH_RXA2:
                    begin
                        scl_next = 1'b0;
                        rcv_next = shift_reg;
                        fin      = 1'b1;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
        end

        // acknowledge sampling
        if (do_poll)
        begin
            if (!cmd.sda_in)
            begin
                scl_next   = 1'b0;
                drive_next = 1'b1;
                fail_next  = 1'b0;
                case (wstep_reg)
                    WSTEP_ADDR:
                    begin
                        wstep_next = WSTEP_REG;
                        shift_next = sreg_reg;
                        bit_next   = '0;
                        enter_en   = 1'b1;
                        enter_ph   = PH_TX1;
                    end
                    WSTEP_REG:
                    begin
                        wstep_next = WSTEP_DATA;
                        shift_next = spay_reg;
                        bit_next   = '0;
                        enter_en   = 1'b1;
                        enter_ph   = PH_TX1;
                    end
                    WSTEP_DATA:
                    begin
                        enter_en = 1'b1;
                        enter_ph = PH_STOP1;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            else if (poll_cnt >= tout_reg)
            begin
                fail_next = 1'b1;
                enter_en  = 1'b1;
                enter_ph  = PH_STOP1;
            end
            else
            begin
                wait_next = poll_cnt + 1'b1;
            end
        end

        // command finished
        if (fin)
        begin
            phase_next = PH_IDLE;
            wstep_next = WSTEP_NONE;
            delay_next = '0;
        end

        // line actions on phase entry
        if (enter_en)
        begin
            case (enter_ph)
                PH_START1:
                begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                end
                PH_START2: sda_next = 1'b0;
                PH_STOP1:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                end
                PH_STOP2: scl_next = 1'b1;
                PH_STOP3: sda_next = 1'b1;
                PH_ACK1:
                begin
                    drive_next = 1'b0;
                    sda_next   = 1'b1;
                end
                PH_ACK2: scl_next = 1'b1;
                PH_TX1:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = shift_next[7];
                    shift_next = {shift_next[6:0], 1'b0};
                end
                PH_TX2: scl_next = 1'b1;
                PH_RX1:
                begin
                    drive_next = 1'b0;
                    scl_next   = 1'b0;
                end
                PH_RX2:
                begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], cmd.sda_in};
                end
                PH_RXA1:
                begin
                    scl_next   = 1'b0;
                    drive_next = 1'b1;
                    sda_next   = !achoice_next;
                end
                PH_RXA2: scl_next = 1'b1;
                default:
                begin
                end
            endcase
            phase_next = enter_ph;
            delay_next = hold;
        end

        done_now = fin;
    end

    // result fields from the updated state
    always_comb
    begin
        result.scl_level   = scl_next;
        result.sda_level   = sda_next;
        result.sda_drive   = drive_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done_now;
        result.rx_byte     = rcv_next;
        result.ack_missing = fail_next;
    end

    // engine state registers, advanced once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_reg     <= '0;
            shift_reg   <= '0;
            delay_reg   <= '0;
            wait_reg    <= '0;
            wstep_reg   <= WSTEP_NONE;
            sreg_reg    <= '0;
            spay_reg    <= '0;
            rcv_reg     <= '0;
            fail_reg    <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            drive_reg   <= 1'b1;
            achoice_reg <= 1'b0;
        end
        else if (push)
        begin
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            delay_reg   <= delay_next;
            wait_reg    <= wait_next;
            wstep_reg   <= wstep_next;
            sreg_reg    <= sreg_next;
            spay_reg    <= spay_next;
            rcv_reg     <= rcv_next;
            fail_reg    <= fail_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            drive_reg   <= drive_next;
            achoice_reg <= achoice_next;
        end
    end

    // output register and skid entry valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // output register and skid entry payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= result;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.scl_level   = out_reg.scl_level;
    assign res.sda_level   = out_reg.sda_level;
    assign res.sda_drive   = out_reg.sda_drive;
    assign res.busy_res    = out_reg.busy_res;
    assign res.done_res    = out_reg.done_res;
    assign res.rx_byte     = out_reg.rx_byte;
    assign res.ack_missing = out_reg.ack_missing;

endmodule

>>> rtl/i2cm_checker.sv
// port-level assertions for the i2c master bit engine and their bind
`timescale 1ns / 1ps

module i2cm_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_ready,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic       res_sda_drive,
    input  logic       res_busy_res,
    input  logic       res_done_res,
    input  logic [7:0] res_rx_byte
);

    // a finished command leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done_res |-> !res_busy_res)
        else $error("done result still shows busy");

    // when idle the master always drives sda
    a_idle_drive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_busy_res |-> res_sda_drive)
        else $error("sda released while idle");

    // requests stall only when results are waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> res_valid)
        else $error("request stalled with no result pending");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_rx_byte)
                                    && $stable(res_done_res))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_sda_drive (res.sda_drive),
    .res_busy_res  (res.busy_res),
    .res_done_res  (res.done_res),
    .res_rx_byte   (res.rx_byte)
);
